>>> rtl/gcpd_pkg.sv
// Shared types and constants for the grid-capped point downsampler.
// Used by the top level and the iterative divider; depends on nothing.
`default_nettype none
package gcpd_pkg;

  localparam int COORD_W    = 20;  // point coordinates and window origins
  localparam int CELL_W     = 16;  // cell size register
  localparam int CAP_W      = 8;   // max_per_cell register
  localparam int CFG_W      = 20;  // widest configuration register
  localparam int CFG_IDX_W  = 2;
  localparam int STATUS_W   = 2;
  localparam int OUT_CNT_W  = 8;
  localparam int DIV_STEP_W = $clog2(COORD_W);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CELL_SIZE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_PER_CELL = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y     = 2'd3;

  // Input action codes
  localparam logic ACT_POINT = 1'b0;
  localparam logic ACT_CLEAR = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] STATUS_KEPT    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_OUTSIDE = 2'd2;

  // Reset values of the configuration registers
  localparam logic [CELL_W-1:0]         CELL_SIZE_RST = 16'd256;
  localparam logic [CAP_W-1:0]          MAX_CELL_RST  = 8'd1;
  localparam logic signed [COORD_W-1:0] ORIGIN_RST    = -20'sd32;

endpackage
`default_nettype wire

>>> rtl/gcpd_ram.sv
// Generic single write port, single read port RAM with registered read data.
// Standalone; holds the per-cell counters of the downsampler.
`default_nettype none
module gcpd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  wire  logic                     clk,
  input  wire  logic                     we,
  input  wire  logic [$clog2(DEPTH)-1:0] waddr,
  input  wire  logic [WIDTH-1:0]         wdata,
  input  wire  logic                     re,
  input  wire  logic [$clog2(DEPTH)-1:0] raddr,
  output logic       [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

>>> rtl/gcpd_div.sv
// Iterative signed-by-unsigned divider, one quotient bit per cycle.
// Truncates toward zero. Depends on gcpd_pkg for the coordinate and cell widths.
`default_nettype none
module gcpd_div (
  input  wire  logic                                clk,
  input  wire  logic                                rst_n,
  input  wire  logic                                start,
  input  wire  logic signed [gcpd_pkg::COORD_W-1:0] dividend,
  input  wire  logic        [gcpd_pkg::CELL_W-1:0]  divisor,
  output logic                                      done,
  output logic signed [gcpd_pkg::COORD_W-1:0]       quotient
);
  import gcpd_pkg::*;

  logic                  busy_r;
  logic                  done_r;
  logic                  neg_r;
  logic [DIV_STEP_W-1:0] step_r;
  logic [CELL_W-1:0]     rem_r;
  logic [CELL_W-1:0]     dvs_r;
  logic [COORD_W-1:0]    mag_r;

  logic [CELL_W:0]       trial;
  logic                  ge;
  logic [CELL_W:0]       diff;

  // Restoring step: bring down the next dividend bit and try a subtract.
  assign trial = {rem_r, mag_r[COORD_W-1]};
  assign ge    = trial >= {1'b0, dvs_r};
  assign diff  = trial - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && step_r == DIV_STEP_W'(COORD_W - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg_r  <= dividend[COORD_W-1];
      mag_r  <= dividend[COORD_W-1] ? COORD_W'(-dividend) : COORD_W'(dividend);
      dvs_r  <= divisor;
      rem_r  <= '0;
      step_r <= '0;
    end else if (busy_r) begin
      rem_r  <= ge ? diff[CELL_W-1:0] : trial[CELL_W-1:0];
      mag_r  <= {mag_r[COORD_W-2:0], ge};
      step_r <= step_r + DIV_STEP_W'(1);
    end
  end

  assign done     = done_r;
  assign quotient = neg_r ? -$signed(mag_r) : $signed(mag_r);

endmodule
`default_nettype wire

>>> rtl/grid_capped_point_downsampler_unit.sv
// Top level of the grid-capped point downsampler: sequencer, configuration
// registers and count memory. Depends on gcpd_pkg, gcpd_div and gcpd_ram.
`default_nettype none
// A point word occupies the block until its result enters the output register,
// and the next word can be taken in the cycle after: the single shared divider
// produces one quotient bit per cycle, twenty for x and then twenty for y,
// followed by a window check, an address multiply, a count memory read and an
// update; a point outside the window skips the last three. A result that finds
// the output register still full waits in the sequencer until it is free.
// A clear word, and likewise reset, starts a clearing pass that zeroes the count
// memory one entry per cycle; no word is taken meanwhile, though configuration
// writes are. A clear produces no result. The next word is taken while a result
// still waits in the output register.
module grid_capped_point_downsampler_unit #(
  parameter int GRID_CELLS_X = 64,
  parameter int GRID_CELLS_Y = 64,
  parameter int COUNT_BITS   = 8
) (
  input  wire  logic                                  clk,
  input  wire  logic                                  rst_n,
  input  wire  logic                                  in_valid,
  output logic                                        in_ready,
  input  wire  logic                                  in_action,
  input  wire  logic signed [gcpd_pkg::COORD_W-1:0]   in_point_x,
  input  wire  logic signed [gcpd_pkg::COORD_W-1:0]   in_point_y,
  output logic                                        out_valid,
  input  wire  logic                                  out_ready,
  output logic signed [gcpd_pkg::COORD_W-1:0]         out_x,
  output logic signed [gcpd_pkg::COORD_W-1:0]         out_y,
  output logic                                        out_keep,
  output logic        [gcpd_pkg::STATUS_W-1:0]        out_status,
  output logic        [gcpd_pkg::OUT_CNT_W-1:0]       out_cell_count,
  input  wire  logic                                  cfg_wr_en,
  input  wire  logic        [gcpd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire  logic        [gcpd_pkg::CFG_W-1:0]     cfg_wdata
);
  import gcpd_pkg::*;

  localparam int DEPTH   = GRID_CELLS_X * GRID_CELLS_Y;
  localparam int AW      = $clog2(DEPTH);
  localparam int XB      = $clog2(GRID_CELLS_X);
  localparam int YB      = $clog2(GRID_CELLS_Y);
  localparam int CMP_W   = 17;
  localparam int CNT_MAX = (1 << COUNT_BITS) - 1;

  typedef enum logic [8:0] {
    S_CLEAR = 9'b000000001,
    S_IDLE  = 9'b000000010,
    S_DIVX  = 9'b000000100,
    S_DIVY  = 9'b000001000,
    S_RANGE = 9'b000010000,
    S_ADDR  = 9'b000100000,
    S_READ  = 9'b001000000,
    S_UPD   = 9'b010000000,
    S_OUT   = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  // Configuration registers
  logic        [CELL_W-1:0]  cell_size_r;
  logic        [CAP_W-1:0]   max_per_cell_r;
  logic signed [COORD_W-1:0] origin_x_r;
  logic signed [COORD_W-1:0] origin_y_r;

  // Working registers
  logic signed [COORD_W-1:0]   px_r;
  logic signed [COORD_W-1:0]   py_r;
  logic signed [COORD_W-1:0]   cx_r;
  logic signed [COORD_W-1:0]   cy_r;
  logic        [XB-1:0]        rx_r;
  logic        [YB-1:0]        ry_r;
  logic        [AW-1:0]        addr_r;
  logic        [AW-1:0]        clr_addr_r;
  logic                        res_keep_r;
  logic        [STATUS_W-1:0]  res_status_r;
  logic        [OUT_CNT_W-1:0] res_count_r;

  // Output register
  logic                        out_valid_r;
  logic signed [COORD_W-1:0]   out_x_r;
  logic signed [COORD_W-1:0]   out_y_r;
  logic                        out_keep_r;
  logic        [STATUS_W-1:0]  out_status_r;
  logic        [OUT_CNT_W-1:0] out_count_r;

  // Divider hookup
  logic                      div_start;
  logic signed [COORD_W-1:0] div_dividend;
  logic        [CELL_W-1:0]  div_divisor;
  logic                      div_done;
  logic signed [COORD_W-1:0] div_quotient;

  // Count memory hookup
  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [COUNT_BITS-1:0] ram_wdata;
  logic                  ram_re;
  logic [COUNT_BITS-1:0] ram_rdata;

  logic                  accept;
  logic                  out_free;
  logic signed [COORD_W:0] rx_full;
  logic signed [COORD_W:0] ry_full;
  logic                  in_window;
  logic [AW-1:0]         addr_calc;
  logic [CMP_W-1:0]      cnt_ext;
  logic [CMP_W-1:0]      cap_ext;
  logic                  cell_has_room;
  logic [COUNT_BITS-1:0] cnt_inc;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  // Cell index relative to the window; a cell is inside when both lie in range.
  assign rx_full   = {cx_r[COORD_W-1], cx_r} - {origin_x_r[COORD_W-1], origin_x_r};
  assign ry_full   = {cy_r[COORD_W-1], cy_r} - {origin_y_r[COORD_W-1], origin_y_r};
  assign in_window = !rx_full[COORD_W] && (rx_full[COORD_W-1:0] < COORD_W'(GRID_CELLS_X))
                  && !ry_full[COORD_W] && (ry_full[COORD_W-1:0] < COORD_W'(GRID_CELLS_Y));

  assign addr_calc = AW'(ry_r) * AW'(GRID_CELLS_X) + AW'(rx_r);

  // The first point of a cell is always kept; otherwise the cap is the
  // smaller of max_per_cell and what the counter can hold.
  assign cnt_ext       = CMP_W'(ram_rdata);
  assign cap_ext       = (CMP_W'(max_per_cell_r) < CMP_W'(CNT_MAX)) ?
                         CMP_W'(max_per_cell_r) : CMP_W'(CNT_MAX);
  assign cell_has_room = (ram_rdata == '0) || (cnt_ext < cap_ext);
  assign cnt_inc       = ram_rdata + COUNT_BITS'(1);

  // The divider works on x first, then on y.
  assign div_start    = (accept && in_action == ACT_POINT) ||
                        (state_r == S_DIVX && div_done);
  assign div_dividend = (state_r == S_IDLE) ? in_point_x : py_r;
  assign div_divisor  = (cell_size_r == '0) ? CELL_W'(1) : cell_size_r;

  assign ram_re    = (state_r == S_READ);
  assign ram_we    = (state_r == S_CLEAR) || (state_r == S_UPD && cell_has_room);
  assign ram_waddr = (state_r == S_CLEAR) ? clr_addr_r : addr_r;
  assign ram_wdata = (state_r == S_CLEAR) ? '0 : cnt_inc;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        if (clr_addr_r == AW'(DEPTH - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (accept) state_nxt = (in_action == ACT_CLEAR) ? S_CLEAR : S_DIVX;
      end
      S_DIVX: begin
        if (div_done) state_nxt = S_DIVY;
      end
      S_DIVY: begin
        if (div_done) state_nxt = S_RANGE;
      end
      S_RANGE: begin
        state_nxt = in_window ? S_ADDR : S_OUT;
      end
      S_ADDR: begin
        state_nxt = S_READ;
      end
      S_READ: begin
        state_nxt = S_UPD;
      end
      S_UPD: begin
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_CLEAR;
      clr_addr_r     <= '0;
      out_valid_r    <= 1'b0;
      cell_size_r    <= CELL_SIZE_RST;
      max_per_cell_r <= MAX_CELL_RST;
      origin_x_r     <= ORIGIN_RST;
      origin_y_r     <= ORIGIN_RST;
    end else begin
      state_r <= state_nxt;

      if (state_r == S_CLEAR) begin
        clr_addr_r <= clr_addr_r + AW'(1);
      end else begin
        clr_addr_r <= '0;
      end

      if (state_r == S_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end

      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_CELL_SIZE:    cell_size_r    <= cfg_wdata[CELL_W-1:0];
          CFG_MAX_PER_CELL: max_per_cell_r <= cfg_wdata[CAP_W-1:0];
          CFG_ORIGIN_X:     origin_x_r     <= $signed(cfg_wdata[COORD_W-1:0]);
          CFG_ORIGIN_Y:     origin_y_r     <= $signed(cfg_wdata[COORD_W-1:0]);
          default: begin
          end
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      px_r <= in_point_x;
      py_r <= in_point_y;
    end
    if (state_r == S_DIVX && div_done) cx_r <= div_quotient;
    if (state_r == S_DIVY && div_done) cy_r <= div_quotient;
    if (state_r == S_RANGE) begin
      rx_r <= rx_full[XB-1:0];
      ry_r <= ry_full[YB-1:0];
      if (!in_window) begin
        res_keep_r   <= 1'b0;
        res_status_r <= STATUS_OUTSIDE;
        res_count_r  <= '0;
      end
    end
    if (state_r == S_ADDR) addr_r <= addr_calc;
    if (state_r == S_UPD) begin
      res_keep_r   <= cell_has_room;
      res_status_r <= cell_has_room ? STATUS_KEPT : STATUS_FULL;
      res_count_r  <= cell_has_room ? OUT_CNT_W'(cnt_inc) : OUT_CNT_W'(ram_rdata);
    end
    if (state_r == S_OUT && out_free) begin
      out_x_r      <= px_r;
      out_y_r      <= py_r;
      out_keep_r   <= res_keep_r;
      out_status_r <= res_status_r;
      out_count_r  <= res_count_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_x          = out_x_r;
  assign out_y          = out_y_r;
  assign out_keep       = out_keep_r;
  assign out_status     = out_status_r;
  assign out_cell_count = out_count_r;

  gcpd_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quotient)
  );

  gcpd_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (DEPTH)
  ) u_count_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (addr_r),
    .rdata (ram_rdata)
  );

`ifndef SYNTH
  // A quotient only ever arrives while the sequencer is waiting for one.
  a_div_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_DIVX || state_r == S_DIVY))
    else $error("divider finished outside a division state");

  // Counts written by a point update are never zero.
  a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (ram_we && state_r == S_UPD) |-> ram_wdata != '0)
    else $error("point update wrote a zero count");

  // A point outside the window is dropped and reports an empty cell.
  a_outside_word: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == STATUS_OUTSIDE) |-> (!out_keep && out_cell_count == '0))
    else $error("outside-window word carries a keep or a count");

  // No word is taken while the count memory is being cleared.
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    $past(state_r == S_CLEAR) && state_r == S_CLEAR |-> !in_ready)
    else $error("input ready during the clearing pass");
`endif

endmodule
`default_nettype wire

>>> tb/tb_top.sv
// Self-checking testbench for grid_capped_point_downsampler_unit: predicts the
// kept/dropped status and cell count of every point word and compares results.
// Depends on gcpd_pkg and the RTL of the downsampler.
`timescale 1ns / 1ps

module tb_top;
  import gcpd_pkg::*;

  localparam int     GRID_X       = 64;
  localparam int     GRID_Y       = 64;
  localparam int     CNT_BITS     = 8;
  localparam int     CNT_MAX      = (1 << CNT_BITS) - 1;
  localparam longint COORD_MIN    = -524288;
  localparam longint COORD_MAX    = 524287;
  localparam int     DRAIN_CYCLES = 100;
  localparam int     STRETCH_1    = 550;
  localparam int     STRETCH_2    = 1100;
  localparam int     CYCLE_LIMIT  = 1500000;

  typedef struct {
    logic                       action;
    logic signed [COORD_W-1:0]  x;
    logic signed [COORD_W-1:0]  y;
  } point_word_t;

  typedef struct {
    logic signed [COORD_W-1:0]  x;
    logic signed [COORD_W-1:0]  y;
    logic                       keep;
    logic        [STATUS_W-1:0] status;
    logic        [OUT_CNT_W-1:0] count;
  } point_result_t;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic                       in_action = ACT_POINT;
  logic signed [COORD_W-1:0]  in_point_x = '0;
  logic signed [COORD_W-1:0]  in_point_y = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic signed [COORD_W-1:0]  out_x;
  logic signed [COORD_W-1:0]  out_y;
  logic                       out_keep;
  logic        [STATUS_W-1:0] out_status;
  logic        [OUT_CNT_W-1:0] out_cell_count;
  logic                       cfg_wr_en = 1'b0;
  logic        [CFG_IDX_W-1:0] cfg_index = CFG_CELL_SIZE;
  logic        [CFG_W-1:0]    cfg_wdata = '0;

  // Shadow copy of the configuration and of the per-cell counts.
  logic        [CELL_W-1:0]   cell_size_q = CELL_SIZE_RST;
  logic        [CAP_W-1:0]    max_per_cell_q = MAX_CELL_RST;
  logic signed [COORD_W-1:0]  origin_x_q = ORIGIN_RST;
  logic signed [COORD_W-1:0]  origin_y_q = ORIGIN_RST;
  int unsigned                cell_tally [GRID_X*GRID_Y];

  point_word_t   point_words [$];
  point_result_t awaited_points [$];
  int            words_queued = 0;
  int            words_taken = 0;
  int            error_count = 0;
  int            cycle_count = 0;

  grid_capped_point_downsampler_unit #(
    .GRID_CELLS_X (GRID_X),
    .GRID_CELLS_Y (GRID_Y),
    .COUNT_BITS   (CNT_BITS)
  ) DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_action      (in_action),
    .in_point_x     (in_point_x),
    .in_point_y     (in_point_y),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_x          (out_x),
    .out_y          (out_y),
    .out_keep       (out_keep),
    .out_status     (out_status),
    .out_cell_count (out_cell_count),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Applies one word to the shadow state; returns 1 when the word yields a result.
  function automatic bit downsample_point(input logic act,
                                          input logic signed [COORD_W-1:0] px,
                                          input logic signed [COORD_W-1:0] py,
                                          output point_result_t res);
    int     div;
    int     cx;
    int     cy;
    longint rx;
    longint ry;
    int     idx;
    int     cnt;
    int     cap;
    res = '{default: '0};
    if (act == ACT_CLEAR) begin
      foreach (cell_tally[i]) cell_tally[i] = 0;
      return 1'b0;
    end
    div = (cell_size_q == 0) ? 1 : int'(cell_size_q);
    // Signed division in SystemVerilog truncates toward zero, as the cell mapping needs.
    cx = int'(px) / div;
    cy = int'(py) / div;
    rx = longint'(cx) - longint'(origin_x_q);
    ry = longint'(cy) - longint'(origin_y_q);
    res.x = px;
    res.y = py;
    if (rx < 0 || rx >= GRID_X || ry < 0 || ry >= GRID_Y) begin
      res.keep   = 1'b0;
      res.status = STATUS_OUTSIDE;
      res.count  = '0;
      return 1'b1;
    end
    idx = int'(ry * GRID_X + rx);
    cnt = int'(cell_tally[idx]);
    cap = (int'(max_per_cell_q) < CNT_MAX) ? int'(max_per_cell_q) : CNT_MAX;
    if (cnt == 0 || cnt < cap) begin
      cnt++;
      cell_tally[idx] = cnt;
      res.keep   = 1'b1;
      res.status = STATUS_KEPT;
    end else begin
      res.keep   = 1'b0;
      res.status = STATUS_FULL;
    end
    res.count = OUT_CNT_W'(cnt);
    return 1'b1;
  endfunction

  function automatic int sender_idle_pct();
    if (words_taken < STRETCH_1) return 9;
    if (words_taken < STRETCH_2) return 51;
    return 0;
  endfunction

  function automatic int receiver_idle_pct();
    if (words_taken < STRETCH_1) return 51;
    if (words_taken < STRETCH_2) return 9;
    return 0;
  endfunction

  // Driver: presents queued words and predicts each one as it is taken.
  always @(posedge clk) begin : driver
    point_result_t res;
    point_word_t   w;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        if (downsample_point(in_action, in_point_x, in_point_y, res))
          awaited_points.insert(awaited_points.size(), res);
        words_taken++;
      end
      if (!in_valid || in_ready) begin
        if (point_words.size() != 0 && $urandom_range(99) >= sender_idle_pct()) begin
          w = point_words.pop_front();
          in_valid   <= 1'b1;
          in_action  <= w.action;
          in_point_x <= w.x;
          in_point_y <= w.y;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result word against the oldest prediction.
  always @(posedge clk) begin : monitor
    point_result_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (awaited_points.size() == 0) begin
          $error("result word (x %0d, y %0d) arrived with no prediction waiting",
                 out_x, out_y);
          error_count++;
        end else begin
          want = awaited_points.pop_front();
          if (out_x !== want.x) begin
            $error("out_x: expected %0d, actual %0d", want.x, out_x);
            error_count++;
          end
          if (out_y !== want.y) begin
            $error("out_y: expected %0d, actual %0d", want.y, out_y);
            error_count++;
          end
          if (out_keep !== want.keep) begin
            $error("out_keep: expected %0d, actual %0d", want.keep, out_keep);
            error_count++;
          end
          if (out_status !== want.status) begin
            $error("out_status: expected %0d, actual %0d", want.status, out_status);
            error_count++;
          end
          if (out_cell_count !== want.count) begin
            $error("out_cell_count: expected %0d, actual %0d", want.count, out_cell_count);
            error_count++;
          end
        end
      end
      out_ready <= ($urandom_range(99) >= receiver_idle_pct());
    end
  end

  always @(posedge clk) begin : watchdog
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic void push_word(input logic act, input logic signed [COORD_W-1:0] x,
                                    input logic signed [COORD_W-1:0] y);
    point_word_t w;
    w.action = act;
    w.x = x;
    w.y = y;
    point_words.insert(point_words.size(), w);
    words_queued++;
  endfunction

  // A coordinate whose truncated quotient by div is the given cell, random otherwise.
  function automatic logic signed [COORD_W-1:0] coord_in_cell(input longint cell_idx,
                                                              input int div);
    longint lo;
    longint hi;
    if (cell_idx > 0) begin
      lo = cell_idx * div;
      hi = lo + div - 1;
    end else if (cell_idx < 0) begin
      hi = cell_idx * div;
      lo = hi - div + 1;
    end else begin
      lo = -(div - 1);
      hi = div - 1;
    end
    if (lo < COORD_MIN) lo = COORD_MIN;
    if (hi > COORD_MAX) hi = COORD_MAX;
    if (lo > hi) return COORD_W'($urandom());
    return COORD_W'(lo + longint'($urandom_range(32'(hi - lo))));
  endfunction

  // Offset into the window, now and then one cell beyond either edge.
  function automatic longint window_offset(input int span);
    int r;
    r = $urandom_range(7);
    if (r == 0) return -1;
    if (r == 1) return span;
    return $urandom_range(span - 1);
  endfunction

  // Mostly points into a few hot cells so that caps are reached, plus noise.
  task automatic push_random(input int n, input int n_hot, input int clear_permille);
    longint hot_cx [8];
    longint hot_cy [8];
    int     div;
    int     pick;
    int     k;
    div = (cell_size_q == 0) ? 1 : int'(cell_size_q);
    for (k = 0; k < n_hot; k++) begin
      hot_cx[k] = longint'(origin_x_q) + window_offset(GRID_X);
      hot_cy[k] = longint'(origin_y_q) + window_offset(GRID_Y);
    end
    repeat (n) begin
      pick = $urandom_range(999);
      if (pick < clear_permille) begin
        push_word(ACT_CLEAR, COORD_W'($urandom()), COORD_W'($urandom()));
      end else if (pick < clear_permille + 150) begin
        push_word(ACT_POINT, COORD_W'($urandom()), COORD_W'($urandom()));
      end else if (pick < clear_permille + 250) begin
        push_word(ACT_POINT,
                  coord_in_cell(longint'(origin_x_q) + window_offset(GRID_X), div),
                  coord_in_cell(longint'(origin_y_q) + window_offset(GRID_Y), div));
      end else begin
        k = $urandom_range(n_hot - 1);
        push_word(ACT_POINT, coord_in_cell(hot_cx[k], div), coord_in_cell(hot_cy[k], div));
      end
    end
  endtask

  // Waits until every word is taken and answered, then lets any clearing pass finish.
  task automatic wait_drained();
    while (words_taken != words_queued || awaited_points.size() != 0 || !in_ready)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_CELL_SIZE:    cell_size_q    = val[CELL_W-1:0];
      CFG_MAX_PER_CELL: max_per_cell_q = val[CAP_W-1:0];
      CFG_ORIGIN_X:     origin_x_q     = val;
      CFG_ORIGIN_Y:     origin_y_q     = val;
      default: ;
    endcase
  endtask

  task automatic set_config(input int cell_len, input int cap, input int ox, input int oy);
    write_reg(CFG_CELL_SIZE, CFG_W'(cell_len));
    write_reg(CFG_MAX_PER_CELL, CFG_W'(cap));
    write_reg(CFG_ORIGIN_X, CFG_W'(ox));
    write_reg(CFG_ORIGIN_Y, CFG_W'(oy));
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin : stimulus
    int cell_len;
    int reach;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    wait_drained();

    // Reset settings: 256-unit cells, cap of one, window from cell -32.
    push_word(ACT_POINT, 0, 0);
    push_word(ACT_POINT, 0, 0);
    push_word(ACT_POINT, 255, 255);
    push_word(ACT_POINT, -1, -1);
    push_word(ACT_POINT, -256, -256);
    push_word(ACT_POINT, -255, 0);
    push_word(ACT_POINT, 524287, 524287);
    push_word(ACT_POINT, -524288, -524288);
    push_word(ACT_POINT, -8192, -8192);
    push_word(ACT_POINT, 8191, 8191);
    push_word(ACT_POINT, 8192, 0);
    push_word(ACT_POINT, -8193, 0);
    push_word(ACT_POINT, -8448, 0);
    push_word(ACT_POINT, 20'sh55555, 20'shAAAAA);
    push_word(ACT_CLEAR, 20'shAAAAA, 20'sh55555);
    push_word(ACT_POINT, 0, 0);
    push_word(ACT_POINT, -8192, -8192);
    wait_drained();

    // A zero cell size behaves as one; a cap of zero still keeps the first point.
    set_config(0, 0, -32, -32);
    push_word(ACT_POINT, 5, 5);
    push_word(ACT_POINT, 5, 5);
    push_word(ACT_POINT, 5, 5);
    push_word(ACT_POINT, -5, -5);
    push_random(150, 6, 20);
    wait_drained();

    set_config(65535, 3, -8, -8);
    push_random(200, 4, 20);
    wait_drained();

    set_config(1, 2, -524288, -524288);
    push_word(ACT_POINT, -524288, -524288);
    push_word(ACT_POINT, -524288, -524288);
    push_word(ACT_POINT, -524288, -524288);
    push_random(150, 6, 20);
    wait_drained();

    set_config(1, 1, 524287, 524287);
    push_word(ACT_POINT, 524287, 524287);
    push_word(ACT_POINT, 524287, 524287);
    push_word(ACT_POINT, 524286, 524287);
    push_random(100, 4, 20);
    wait_drained();

    // Widest cap: most points go to a single hot cell, which can fill to 255 and then drop points.
    set_config(300, 255, -40, -10);
    push_random(650, 1, 2);
    wait_drained();

    repeat (2) begin
      cell_len = $urandom_range(2000, 2);
      reach    = 524288 / cell_len;
      set_config(cell_len, $urandom_range(6),
                 $urandom_range(2 * reach + 8) - reach - 40,
                 $urandom_range(2 * reach + 8) - reach - 40);
      push_random(200, 5, 20);
      wait_drained();
    end

    if (error_count == 0 && awaited_points.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/gcpd_pkg.sv
rtl/gcpd_ram.sv
rtl/gcpd_div.sv
rtl/grid_capped_point_downsampler_unit.sv
tb/tb_top.sv
